/* rtl/fpe_pkg.sv */
// Shared types and constants for the frustum plane extract and test unit.
`default_nettype none
package fpe_pkg;

	localparam logic [1:0] FUNC_LOAD    = 2'd0;
	localparam logic [1:0] FUNC_EXTRACT = 2'd1;
	localparam logic [1:0] FUNC_QUERY   = 2'd2;
	localparam logic [1:0] FUNC_RSVD    = 2'd3;

	localparam logic KIND_PLANE = 1'b0;
	localparam logic KIND_DIST  = 1'b1;

	localparam logic [2:0] LAST_PLANE = 3'd5;

	localparam int NORM_SHIFT = 30;
	// 66-bit sum of squares: one root bit per bit pair
	localparam int SQRT_STEPS = 33;
	localparam int DIV_STEPS  = 63;
	localparam int CMDQ_DEPTH = 4;
	localparam int OUTQ_DEPTH = 4;

	typedef struct packed {
		logic [1:0]  func;
		logic [1:0]  column;
		logic [1:0]  row;
		logic [31:0] element;
		logic [31:0] point_x;
		logic [31:0] point_y;
		logic [31:0] point_z;
	} cmd_t;

	typedef struct packed {
		logic        kind;
		logic [2:0]  plane_index;
		logic [31:0] normal_x;
		logic [31:0] normal_y;
		logic [31:0] normal_z;
		logic [31:0] offset;
		logic [31:0] distance;
		logic        flagged;
		logic        last;
	} res_t;

	typedef struct packed {
		logic [2:0]  idx;
		logic        last;
		logic [31:0] nx;
		logic [31:0] ny;
		logic [31:0] nz;
		logic [31:0] offset;
		logic        flag;
	} qplane_t;

	// matrix row combined with row 3 for each plane
	function automatic logic [1:0] plane_row(input logic [2:0] p);
		logic [1:0] r;
		case (p)
			3'd0, 3'd1: r = 2'd2;
			3'd2, 3'd3: r = 2'd0;
			default:    r = 2'd1;
		endcase
		return r;
	endfunction

	// far, right and top subtract the row
	function automatic logic plane_sub(input logic [2:0] p);
		return (p == 3'd1) || (p == 3'd3) || (p == 3'd4);
	endfunction

	function automatic logic [32:0] mag33(input logic [32:0] v);
		return v[32] ? (33'd0 - v) : v;
	endfunction

endpackage
`default_nettype wire

/* rtl/fpe_front.sv */
// Front end: request intake, classification and command queue.
`default_nettype none
module fpe_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	output logic                     full,
	input  wire logic [1:0]          func,
	input  wire logic [1:0]          column,
	input  wire logic [1:0]          row,
	input  wire logic signed [31:0]  element,
	input  wire logic signed [31:0]  point_x,
	input  wire logic signed [31:0]  point_y,
	input  wire logic signed [31:0]  point_z,
	output fpe_pkg::cmd_t            cmd,
	output logic                     cmd_empty,
	input  wire logic                cmd_pop
);
	fpe_pkg::cmd_t mem_q [fpe_pkg::CMDQ_DEPTH];
	logic [1:0] wr_ptr_q, rd_ptr_q;
	logic [2:0] cnt_q;
	logic       enq, deq;

	// reserved func codes are taken and dropped
	assign full      = (cnt_q == 3'(fpe_pkg::CMDQ_DEPTH));
	assign cmd_empty = (cnt_q == 3'd0);
	assign enq       = push && !full && (func != fpe_pkg::FUNC_RSVD);
	assign deq       = cmd_pop && !cmd_empty;
	assign cmd       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (enq) begin
			mem_q[wr_ptr_q] <= '{func: func, column: column, row: row,
				element: element, point_x: point_x, point_y: point_y, point_z: point_z};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (enq) wr_ptr_q <= wr_ptr_q + 2'd1;
			if (deq) rd_ptr_q <= rd_ptr_q + 2'd1;
			if (enq && !deq) cnt_q <= cnt_q + 3'd1;
			else if (deq && !enq) cnt_q <= cnt_q - 3'd1;
		end
	end
endmodule
`default_nettype wire

/* rtl/fpe_query.sv */
// Point distance pipeline: three multipliers, sum, floor shift and saturation.
`default_nettype none
module fpe_query (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               adv,
	input  wire logic               issue,
	input  wire logic signed [31:0] pt_x,
	input  wire logic signed [31:0] pt_y,
	input  wire logic signed [31:0] pt_z,
	input  fpe_pkg::qplane_t        plane,
	output logic                    wr,
	output fpe_pkg::res_t           res,
	output logic                    busy
);
	logic v_s1, v_s2, v_s3;
	logic signed [63:0] prx_s1, pry_s1, prz_s1;
	logic [31:0] off_s1, off_s2;
	logic [2:0]  idx_s1, idx_s2;
	logic        flag_s1, flag_s2, last_s1, last_s2;
	logic [65:0] acc_s2;
	fpe_pkg::res_t res_s3;

	logic [65:0] acc_w;
	logic [36:0] dsum;
	logic        sat_hi, sat_lo;
	logic [31:0] dist_w;

	assign acc_w = {{2{prx_s1[63]}}, prx_s1} + {{2{pry_s1[63]}}, pry_s1}
		+ {{2{prz_s1[63]}}, prz_s1};
	// floor divide by 2^30 is the arithmetic shift
	assign dsum   = {acc_s2[65], acc_s2[65:30]} + {{5{off_s2[31]}}, off_s2};
	assign sat_hi = !dsum[36] && (dsum[35:31] != 5'h00);
	assign sat_lo =  dsum[36] && (dsum[35:31] != 5'h1F);
	assign dist_w = sat_hi ? 32'h7FFF_FFFF : (sat_lo ? 32'h8000_0000 : dsum[31:0]);

	assign wr   = v_s3 && adv;
	assign res  = res_s3;
	assign busy = v_s1 || v_s2 || v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prx_s1  <= pt_x * $signed(plane.nx);
			pry_s1  <= pt_y * $signed(plane.ny);
			prz_s1  <= pt_z * $signed(plane.nz);
			off_s1  <= plane.offset;
			idx_s1  <= plane.idx;
			flag_s1 <= plane.flag;
			last_s1 <= plane.last;
			acc_s2  <= acc_w;
			off_s2  <= off_s1;
			idx_s2  <= idx_s1;
			flag_s2 <= flag_s1;
			last_s2 <= last_s1;
			res_s3  <= '{kind: fpe_pkg::KIND_DIST, plane_index: idx_s2,
				normal_x: 32'd0, normal_y: 32'd0, normal_z: 32'd0, offset: 32'd0,
				distance: dist_w, flagged: flag_s2 || sat_hi || sat_lo, last: last_s2};
		end
	end
endmodule
`default_nettype wire

/* rtl/fpe_outq.sv */
// Result queue between the back end and the result ports.
`default_nettype none
module fpe_outq (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     wr,
	input  fpe_pkg::res_t wdata,
	output logic          full,
	output logic          empty,
	input  wire logic     pop,
	output fpe_pkg::res_t rdata
);
	fpe_pkg::res_t mem_q [fpe_pkg::OUTQ_DEPTH];
	logic [1:0] wr_ptr_q, rd_ptr_q;
	logic [2:0] cnt_q;
	logic       enq, deq;

	assign full  = (cnt_q == 3'(fpe_pkg::OUTQ_DEPTH));
	assign empty = (cnt_q == 3'd0);
	assign enq   = wr && !full;
	assign deq   = pop && !empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (enq) mem_q[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (enq) wr_ptr_q <= wr_ptr_q + 2'd1;
			if (deq) rd_ptr_q <= rd_ptr_q + 2'd1;
			if (enq && !deq) cnt_q <= cnt_q + 3'd1;
			else if (deq && !enq) cnt_q <= cnt_q - 3'd1;
		end
	end
endmodule
`default_nettype wire

/* rtl/fpe_back.sv */
// Back end: sequencer, matrix and plane stores, square root and divider.
`default_nettype none
module fpe_back #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  fpe_pkg::cmd_t cmd,
	input  wire logic     cmd_empty,
	output logic          cmd_pop,
	input  wire logic     fifo_full,
	output logic          out_wr,
	output fpe_pkg::res_t out_res
);
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_QRY   = 3'd1;
	localparam logic [2:0] ST_XN    = 3'd2;
	localparam logic [2:0] ST_XSQ   = 3'd3;
	localparam logic [2:0] ST_XSQRT = 3'd4;
	localparam logic [2:0] ST_XDIV  = 3'd5;
	localparam logic [2:0] ST_XEMIT = 3'd6;

	logic [2:0]  state_q, p_q;
	logic [1:0]  k_q;
	logic [5:0]  cnt_q;
	logic [31:0] mat_q [16];
	logic [31:0] nrm_q [6][3];
	logic [31:0] off_q [6];
	logic [5:0]  flg_q;

	logic [32:0] n_q [4];
	logic [65:0] s_q, prod_q, rad_q;
	logic [33:0] root_q;
	logic [35:0] srem_q;
	logic [62:0] num_q, quo_q;
	logic [33:0] drem_q;
	logic        neg_q;
	logic [31:0] ptx_q, pty_q, ptz_q;

	logic        adv, issue, q_wr, q_busy, emit_wr;
	logic [2:0]  iss_p;
	fpe_pkg::qplane_t qplane;
	fpe_pkg::res_t    q_res, emit_res;
	logic [31:0] ipx, ipy, ipz;
	logic [32:0] nn [4];
	logic [1:0]  prow;
	logic        psub;
	logic [32:0] sq_mg;
	logic [65:0] sq_w;
	logic [37:0] srt_tr, srt_tv;
	logic        srt_ge;
	logic [35:0] srt_rem_nx;
	logic [33:0] root_nx;
	logic [34:0] dv_tr;
	logic        dv_ge;
	logic [33:0] dv_rem_nx;
	logic [62:0] quo_nx;
	logic [1:0]  ks;
	logic [32:0] set_mg;
	logic [62:0] num_set;
	logic [31:0] nrm_val, off_val;
	logic        off_sat;

	assign adv = !fifo_full;

	// query issue: plane 0 straight from the queue head, the rest from latched point
	assign issue = adv && ((state_q == ST_IDLE && !cmd_empty && cmd.func == fpe_pkg::FUNC_QUERY)
		|| state_q == ST_QRY);
	assign iss_p = (state_q == ST_IDLE) ? 3'd0 : p_q;
	assign ipx   = (state_q == ST_IDLE) ? cmd.point_x : ptx_q;
	assign ipy   = (state_q == ST_IDLE) ? cmd.point_y : pty_q;
	assign ipz   = (state_q == ST_IDLE) ? cmd.point_z : ptz_q;
	assign qplane = '{idx: iss_p, last: iss_p == fpe_pkg::LAST_PLANE,
		nx: nrm_q[iss_p][0], ny: nrm_q[iss_p][1], nz: nrm_q[iss_p][2],
		offset: off_q[iss_p], flag: flg_q[iss_p]};

	fpe_query u_query (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.issue  (issue),
		.pt_x   ($signed(ipx)),
		.pt_y   ($signed(ipy)),
		.pt_z   ($signed(ipz)),
		.plane  (qplane),
		.wr     (q_wr),
		.res    (q_res),
		.busy   (q_busy)
	);

	always_comb begin
		cmd_pop = 1'b0;
		if (state_q == ST_IDLE && !cmd_empty) begin
			case (cmd.func)
				fpe_pkg::FUNC_LOAD:    cmd_pop = 1'b1;
				fpe_pkg::FUNC_QUERY:   cmd_pop = adv;
				fpe_pkg::FUNC_EXTRACT: cmd_pop = !q_busy;
				default:               cmd_pop = 1'b1;
			endcase
		end
	end

	// plane sums from column c: row 3 plus or minus the plane's row
	assign prow = fpe_pkg::plane_row(p_q);
	assign psub = fpe_pkg::plane_sub(p_q);
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			nn[c] = psub
				? {mat_q[{2'(c), 2'd3}][31], mat_q[{2'(c), 2'd3}]}
					- {mat_q[{2'(c), prow}][31], mat_q[{2'(c), prow}]}
				: {mat_q[{2'(c), 2'd3}][31], mat_q[{2'(c), 2'd3}]}
					+ {mat_q[{2'(c), prow}][31], mat_q[{2'(c), prow}]};
		end
	end

	assign sq_mg = fpe_pkg::mag33(n_q[k_q]);
	assign sq_w  = sq_mg * sq_mg;

	// one root bit per step
	assign srt_tr     = {srem_q, rad_q[65:64]};
	assign srt_tv     = {2'd0, root_q, 2'b01};
	assign srt_ge     = (srt_tr >= srt_tv);
	assign srt_rem_nx = srt_ge ? 36'(srt_tr - srt_tv) : srt_tr[35:0];
	assign root_nx    = {root_q[32:0], srt_ge};

	// restoring divide by the root, one quotient bit per step
	assign dv_tr     = {drem_q, num_q[62]};
	assign dv_ge     = (dv_tr >= {1'b0, root_q});
	assign dv_rem_nx = dv_ge ? 34'(dv_tr - {1'b0, root_q}) : dv_tr[33:0];
	assign quo_nx    = {quo_q[61:0], dv_ge};

	assign ks      = (state_q == ST_XSQRT) ? 2'd0 : (k_q + 2'd1);
	assign set_mg  = fpe_pkg::mag33(n_q[ks]);
	assign num_set = (ks == 2'd3) ? (63'(set_mg) << FRAC_BITS)
		: {set_mg, {fpe_pkg::NORM_SHIFT{1'b0}}};

	assign nrm_val = neg_q ? (32'd0 - quo_nx[31:0]) : quo_nx[31:0];
	assign off_sat = (!neg_q && quo_nx > 63'h7FFF_FFFF) || (neg_q && quo_nx > 63'h8000_0000);
	assign off_val = off_sat ? (neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF) : nrm_val;

	assign emit_wr  = (state_q == ST_XEMIT) && adv;
	assign emit_res = '{kind: fpe_pkg::KIND_PLANE, plane_index: p_q,
		normal_x: nrm_q[p_q][0], normal_y: nrm_q[p_q][1], normal_z: nrm_q[p_q][2],
		offset: off_q[p_q], distance: 32'd0, flagged: flg_q[p_q],
		last: p_q == fpe_pkg::LAST_PLANE};

	assign out_wr  = emit_wr || q_wr;
	assign out_res = emit_wr ? emit_res : q_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			p_q     <= '0;
			k_q     <= '0;
			cnt_q   <= '0;
			flg_q   <= '0;
			for (int i = 0; i < 16; i++) mat_q[i] <= '0;
			for (int i = 0; i < 6; i++) begin
				off_q[i] <= '0;
				for (int j = 0; j < 3; j++) nrm_q[i][j] <= '0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (!cmd_empty) begin
						if (cmd.func == fpe_pkg::FUNC_LOAD) begin
							mat_q[{cmd.column, cmd.row}] <= cmd.element;
						end else if (cmd.func == fpe_pkg::FUNC_QUERY) begin
							if (adv) begin
								p_q     <= 3'd1;
								state_q <= ST_QRY;
							end
						end else if (cmd.func == fpe_pkg::FUNC_EXTRACT && !q_busy) begin
							p_q     <= 3'd0;
							state_q <= ST_XN;
						end
					end
				end
				ST_QRY: begin
					if (adv) begin
						if (p_q == fpe_pkg::LAST_PLANE) state_q <= ST_IDLE;
						else p_q <= p_q + 3'd1;
					end
				end
				ST_XN: begin
					k_q     <= 2'd0;
					state_q <= ST_XSQ;
				end
				ST_XSQ: begin
					k_q <= k_q + 2'd1;
					if (k_q == 2'd3) begin
						cnt_q   <= '0;
						state_q <= ST_XSQRT;
					end
				end
				ST_XSQRT: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(fpe_pkg::SQRT_STEPS - 1)) begin
						cnt_q <= '0;
						k_q   <= 2'd0;
						if (root_nx == '0) begin
							// degenerate plane
							for (int j = 0; j < 3; j++) nrm_q[p_q][j] <= '0;
							off_q[p_q] <= '0;
							flg_q[p_q] <= 1'b1;
							state_q    <= ST_XEMIT;
						end else begin
							state_q <= ST_XDIV;
						end
					end
				end
				ST_XDIV: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(fpe_pkg::DIV_STEPS - 1)) begin
						cnt_q <= '0;
						if (k_q == 2'd3) begin
							off_q[p_q] <= off_val;
							flg_q[p_q] <= off_sat;
							state_q    <= ST_XEMIT;
						end else begin
							nrm_q[p_q][k_q] <= nrm_val;
							k_q             <= k_q + 2'd1;
						end
					end
				end
				ST_XEMIT: begin
					if (adv) begin
						if (p_q == fpe_pkg::LAST_PLANE) begin
							state_q <= ST_IDLE;
						end else begin
							p_q     <= p_q + 3'd1;
							state_q <= ST_XN;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd_pop && cmd.func == fpe_pkg::FUNC_QUERY) begin
			ptx_q <= cmd.point_x;
			pty_q <= cmd.point_y;
			ptz_q <= cmd.point_z;
		end
		case (state_q)
			ST_XN: begin
				n_q <= nn;
				s_q <= '0;
			end
			ST_XSQ: begin
				if (k_q != 2'd3) prod_q <= sq_w;
				if (k_q != 2'd0) s_q <= s_q + prod_q;
				if (k_q == 2'd3) begin
					rad_q  <= s_q + prod_q;
					root_q <= '0;
					srem_q <= '0;
				end
			end
			ST_XSQRT: begin
				rad_q  <= rad_q << 2;
				root_q <= root_nx;
				srem_q <= srt_rem_nx;
				if (cnt_q == 6'(fpe_pkg::SQRT_STEPS - 1)) begin
					num_q  <= num_set;
					drem_q <= '0;
					quo_q  <= '0;
					neg_q  <= n_q[ks][32];
				end
			end
			ST_XDIV: begin
				num_q  <= num_q << 1;
				drem_q <= dv_rem_nx;
				quo_q  <= quo_nx;
				if (cnt_q == 6'(fpe_pkg::DIV_STEPS - 1) && k_q != 2'd3) begin
					num_q  <= num_set;
					drem_q <= '0;
					quo_q  <= '0;
					neg_q  <= n_q[ks][32];
				end
			end
			default: ;
		endcase
	end

	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		!(emit_wr && q_wr)) else $error("plane emit collides with distance result");
	a_issue_room: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> !fifo_full) else $error("query issued while result queue full");
	a_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_XN) |-> !q_busy) else $error("extraction overlaps a query");
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_XDIV) |-> (root_q != '0 && drem_q < root_q))
		else $error("divider remainder out of range");
endmodule
`default_nettype wire

/* rtl/frustum_plane_extract_and_test_unit.sv */
// Top level of the frustum plane extract and test unit.
//
//  channel   handshake          payload
//  request   push / full        func column row element point_x point_y point_z
//  result    empty / pop        kind plane_index normal_x/y/z offset distance flagged last
//
// A load writes one matrix element in the back end. A point query issues one plane per cycle
// while the result queue has room, into a three-multiplier pipeline; a new query can issue
// while the planes of the last one are still in it. Extraction runs per plane 1 setup,
// 4 square steps, 33 root steps, 4 x 63 divide steps and 1 emit, most of them in the
// bit-serial root and divider; a degenerate plane skips the divide.
// Reset clears the matrix and plane stores to zero at once.
// A full result queue stalls query issue and plane emits; requests still queue up to four deep.
`default_nettype none
module frustum_plane_extract_and_test_unit #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire logic [1:0]         func,
	input  wire logic [1:0]         column,
	input  wire logic [1:0]         row,
	input  wire logic signed [31:0] element,
	input  wire logic signed [31:0] point_x,
	input  wire logic signed [31:0] point_y,
	input  wire logic signed [31:0] point_z,
	output logic                    empty,
	input  wire logic               pop,
	output logic                    kind,
	output logic [2:0]              plane_index,
	output logic signed [31:0]      normal_x,
	output logic signed [31:0]      normal_y,
	output logic signed [31:0]      normal_z,
	output logic signed [31:0]      offset,
	output logic signed [31:0]      distance,
	output logic                    flagged,
	output logic                    last
);
	fpe_pkg::cmd_t cmd;
	fpe_pkg::res_t wres, rres;
	logic cmd_empty, cmd_pop, out_wr, out_full;

	// front: takes requests, drops reserved codes, queues the rest in order
	fpe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.func      (func),
		.column    (column),
		.row       (row),
		.element   (element),
		.point_x   (point_x),
		.point_y   (point_y),
		.point_z   (point_z),
		.cmd       (cmd),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop)
	);

	// back: loads, extraction and queries, strictly in request order
	fpe_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.fifo_full (out_full),
		.out_wr    (out_wr),
		.out_res   (wres)
	);

	fpe_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (out_wr),
		.wdata  (wres),
		.full   (out_full),
		.empty  (empty),
		.pop    (pop),
		.rdata  (rres)
	);

	assign kind        = rres.kind;
	assign plane_index = rres.plane_index;
	assign normal_x    = rres.normal_x;
	assign normal_y    = rres.normal_y;
	assign normal_z    = rres.normal_z;
	assign offset      = rres.offset;
	assign distance    = rres.distance;
	assign flagged     = rres.flagged;
	assign last        = rres.last;
endmodule
`default_nettype wire

/* sim/tb_frustum_plane_extract_and_test_unit.sv */
// Testbench for the frustum plane extract and test unit: self-checking, queue handshakes.
`default_nettype none
module tb_frustum_plane_extract_and_test_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC = 16;

	// One request waiting to be driven. When hold_for_drain is set, the driver
	// waits until every result already predicted has come out.
	typedef struct {
		fpe_pkg::cmd_t c;
		bit            hold_for_drain;
	} request_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic [1:0] func = fpe_pkg::FUNC_RSVD;
	logic [1:0] column = '0;
	logic [1:0] row = '0;
	logic signed [31:0] element = '0;
	logic signed [31:0] point_x = '0;
	logic signed [31:0] point_y = '0;
	logic signed [31:0] point_z = '0;
	logic full, empty, kind, flagged, last;
	logic [2:0] plane_index;
	logic signed [31:0] normal_x, normal_y, normal_z, offset, distance;

	frustum_plane_extract_and_test_unit #(.FRAC_BITS(FRAC)) i_dut (
		.clk, .arst_n, .push, .full, .func, .column, .row, .element,
		.point_x, .point_y, .point_z, .empty, .pop, .kind, .plane_index,
		.normal_x, .normal_y, .normal_z, .offset, .distance, .flagged, .last
	);

	always #5 clk = ~clk;

	// Shadow copy of the block's state.
	logic signed [31:0] shadow_matrix [16];
	logic signed [31:0] shadow_normal [18];
	logic signed [31:0] shadow_offset [6];
	bit                 shadow_flag   [6];

	request_t      request_queue[$];
	fpe_pkg::res_t pending_results[$];

	int  errors = 0;
	int  n_accepted = 0;
	int  n_checked = 0;
	int  n_extract = 0;
	int  n_query = 0;
	int  n_degenerate = 0;
	int  n_saturated = 0;
	int  tx_idle = 0;
	int  rx_idle = 0;
	bit  rx_hold = 1'b0;
	bit  took = 1'b0;
	bit  quiet = 1'b0;
	fpe_pkg::cmd_t driven;

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		errors++;
		$display("MISMATCH %s: got %h expected %h (result %0d)", what, got, want, n_checked);
	endtask

	function automatic logic [71:0] floor_root(input logic [71:0] s);
		logic [71:0] r, c;
		r = '0;
		for (int b = 33; b >= 0; b--) begin
			c = r | (72'd1 << b);
			if (c * c <= s)
				r = c;
		end
		return r;
	endfunction

	function automatic logic [1:0] plane_row_of(input int p);
		return (p < 2) ? 2'd2 : (p < 4) ? 2'd0 : 2'd1;
	endfunction

	// far, right and top take the difference
	function automatic bit plane_subtracts(input int p);
		return p == 1 || p == 3 || p == 4;
	endfunction

	// Forms the six planes from the shadow matrix (row 3 plus or minus one row).
	task automatic extract_shadow_planes();
		logic signed [95:0] n [4];
		logic signed [95:0] base, other, q, lsig;
		logic [71:0] s, len;
		logic [1:0] prow;
		for (int p = 0; p < 6; p++) begin
			prow = plane_row_of(p);
			s = '0;
			for (int c = 0; c < 4; c++) begin
				base = shadow_matrix[c*4+3];
				other = shadow_matrix[c*4+prow];
				n[c] = plane_subtracts(p) ? base - other : base + other;
				if (c < 3)
					s += 72'(n[c] * n[c]);
			end
			len = floor_root(s);
			if (len == 0) begin
				for (int c = 0; c < 3; c++)
					shadow_normal[p*3+c] = '0;
				shadow_offset[p] = '0;
				shadow_flag[p] = 1'b1;
				n_degenerate++;
			end else begin
				lsig = $signed({24'd0, len});
				for (int c = 0; c < 3; c++) begin
					q = (n[c] <<< 30) / lsig;
					shadow_normal[p*3+c] = q[31:0];
				end
				q = (n[3] <<< FRAC) / lsig;
				shadow_flag[p] = 1'b0;
				if (q > 96'sd2147483647) begin
					shadow_offset[p] = 32'h7fffffff;
					shadow_flag[p] = 1'b1;
					n_saturated++;
				end else if (q < -96'sd2147483648) begin
					shadow_offset[p] = 32'h80000000;
					shadow_flag[p] = 1'b1;
					n_saturated++;
				end else
					shadow_offset[p] = q[31:0];
			end
		end
	endtask

	// Updates the shadow state for one accepted request and queues its results.
	task automatic compute_plane_results(input fpe_pkg::cmd_t c);
		fpe_pkg::res_t r;
		logic signed [95:0] acc, px, py, pz, d;
		if (c.func == fpe_pkg::FUNC_LOAD) begin
			shadow_matrix[{c.column, c.row}] = c.element;
		end else if (c.func != fpe_pkg::FUNC_RSVD) begin
			if (c.func == fpe_pkg::FUNC_EXTRACT) begin
				extract_shadow_planes();
				n_extract++;
			end else
				n_query++;
			px = $signed(c.point_x);
			py = $signed(c.point_y);
			pz = $signed(c.point_z);
			for (int p = 0; p < 6; p++) begin
				r = '0;
				r.plane_index = 3'(p);
				r.last = (p == fpe_pkg::LAST_PLANE);
				if (c.func == fpe_pkg::FUNC_EXTRACT) begin
					r.kind = fpe_pkg::KIND_PLANE;
					r.normal_x = shadow_normal[p*3];
					r.normal_y = shadow_normal[p*3+1];
					r.normal_z = shadow_normal[p*3+2];
					r.offset = shadow_offset[p];
					r.flagged = shadow_flag[p];
				end else begin
					r.kind = fpe_pkg::KIND_DIST;
					acc = px * shadow_normal[p*3] + py * shadow_normal[p*3+1]
						+ pz * shadow_normal[p*3+2];
					d = (acc >>> 30) + shadow_offset[p];
					r.flagged = shadow_flag[p];
					if (d > 96'sd2147483647) begin
						r.distance = 32'h7fffffff;
						r.flagged = 1'b1;
					end else if (d < -96'sd2147483648) begin
						r.distance = 32'h80000000;
						r.flagged = 1'b1;
					end else
						r.distance = d[31:0];
				end
				pending_results.push_back(r);
			end
		end
	endtask

	// Acceptance of requests and results is decided on the rising edge.
	always @(posedge clk) begin
		took = arst_n && push && !full;
		if (took) begin
			compute_plane_results(driven);
			n_accepted++;
		end
		if (arst_n && pop && !empty) begin
			if (pending_results.size() == 0) begin
				report("unexpected result, plane", 32'(plane_index), 32'd0);
			end else begin
				fpe_pkg::res_t w;
				w = pending_results.pop_front();
				if (kind !== w.kind) report("kind", 32'(kind), 32'(w.kind));
				if (plane_index !== w.plane_index)
					report("plane_index", 32'(plane_index), 32'(w.plane_index));
				if (normal_x !== w.normal_x) report("normal_x", normal_x, w.normal_x);
				if (normal_y !== w.normal_y) report("normal_y", normal_y, w.normal_y);
				if (normal_z !== w.normal_z) report("normal_z", normal_z, w.normal_z);
				if (offset !== w.offset) report("offset", offset, w.offset);
				if (distance !== w.distance) report("distance", distance, w.distance);
				if (flagged !== w.flagged) report("flagged", 32'(flagged), 32'(w.flagged));
				if (last !== w.last) report("last", 32'(last), 32'(w.last));
			end
			n_checked++;
		end
	end

	// Request driver: a new request only once the current one has gone in.
	always @(negedge clk) begin
		bit            nx_push;
		fpe_pkg::cmd_t nx;
		request_t      rq;
		nx_push = push;
		nx = driven;
		quiet = request_queue.size() < 40;
		if (arst_n && (!push || took)) begin
			nx_push = 1'b0;
			if (tx_idle > 0)
				tx_idle--;
			else if (request_queue.size() > 0 &&
					!(request_queue[0].hold_for_drain && pending_results.size() > 0)) begin
				rq = request_queue.pop_front();
				nx = rq.c;
				nx_push = 1'b1;
				if (!quiet && $urandom_range(0, 7) == 0)
					tx_idle = $urandom_range(1, 17);
			end
		end
		driven = nx;
		push <= nx_push;
		func <= nx.func;
		column <= nx.column;
		row <= nx.row;
		element <= nx.element;
		point_x <= nx.point_x;
		point_y <= nx.point_y;
		point_z <= nx.point_z;
	end

	// Result side: random pop bursts, plus the long hold below.
	always @(negedge clk) begin
		if (rx_idle > 0)
			rx_idle--;
		else if (!quiet && $urandom_range(0, 7) == 0)
			rx_idle = $urandom_range(1, 17);
		pop <= arst_n && !rx_hold && rx_idle == 0;
	end

	// Long receiver stall while requests keep coming, so both queues back up.
	initial begin
		wait (n_accepted >= 60);
		@(negedge clk);
		rx_hold = 1'b1;
		repeat (400) @(negedge clk);
		rx_hold = 1'b0;
	end

	initial begin
		#5000000;
		$display("timeout");
		$display("tb_frustum_plane_extract_and_test_unit NOT OK");
		$finish;
	end

	task automatic add_load(input logic [1:0] col, input logic [1:0] r,
			input logic [31:0] v, input bit hold);
		request_t q;
		q.c = '0;
		q.c.func = fpe_pkg::FUNC_LOAD;
		q.c.column = col;
		q.c.row = r;
		q.c.element = v;
		q.c.point_x = $urandom();
		q.hold_for_drain = hold;
		request_queue.push_back(q);
	endtask

	task automatic add_op(input logic [1:0] f, input logic [31:0] x,
			input logic [31:0] y, input logic [31:0] z, input bit hold);
		request_t q;
		q.c = '0;
		q.c.func = f;
		q.c.column = 2'($urandom());
		q.c.row = 2'($urandom());
		q.c.element = $urandom();
		q.c.point_x = x;
		q.c.point_y = y;
		q.c.point_z = z;
		q.hold_for_drain = hold;
		request_queue.push_back(q);
	endtask

	// Mix of full-range, modest, extreme and zero values.
	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 5))
			0, 1: return $urandom();
			2, 3: return 32'($signed($urandom_range(0, 32'h3ffff)) - 32'sh1ffff);
			4: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
			default: return '0;
		endcase
	endfunction

	initial begin
		int order [16];
		int n_frames;
		// Directed: reset state, all-zero matrix, reserved code, a simple
		// projection, then extremes that force offset and distance saturation.
		add_op(fpe_pkg::FUNC_QUERY, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 1'b0);
		add_op(fpe_pkg::FUNC_EXTRACT, '0, '0, '0, 1'b0);
		add_op(fpe_pkg::FUNC_RSVD, '0, '0, '0, 1'b0);
		add_op(fpe_pkg::FUNC_QUERY, 32'h00010000, '0, '0, 1'b0);
		add_load(2'd0, 2'd0, 32'h00010000, 1'b0);
		add_load(2'd1, 2'd1, 32'h00010000, 1'b0);
		add_load(2'd2, 2'd2, 32'hffff0000, 1'b0);
		add_load(2'd2, 2'd3, 32'hffff0000, 1'b0);
		add_load(2'd3, 2'd2, 32'hfffe0000, 1'b0);
		add_op(fpe_pkg::FUNC_EXTRACT, '0, '0, '0, 1'b0);
		add_op(fpe_pkg::FUNC_QUERY, 32'h00020000, 32'hffff8000, 32'hfffb0000, 1'b0);
		add_op(fpe_pkg::FUNC_QUERY, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 1'b0);
		add_load(2'd3, 2'd3, 32'h7fffffff, 1'b0);
		add_load(2'd0, 2'd3, 32'h00000001, 1'b0);
		add_load(2'd3, 2'd0, 32'h80000000, 1'b0);
		add_load(2'd1, 2'd0, 32'h80000000, 1'b0);
		add_op(fpe_pkg::FUNC_EXTRACT, '0, '0, '0, 1'b0);
		add_op(fpe_pkg::FUNC_QUERY, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b0);
		add_op(fpe_pkg::FUNC_QUERY, 32'h80000000, 32'h80000000, 32'h80000000, 1'b0);
		add_op(fpe_pkg::FUNC_RSVD, 32'hffffffff, 32'hffffffff, 32'hffffffff, 1'b0);
		// Random frames: a full matrix load in random order, one extraction,
		// a run of queries; now and then noise or a frame cut short.
		n_frames = 0;
		while (request_queue.size() < 410) begin
			for (int i = 0; i < 16; i++)
				order[i] = i;
			order.shuffle();
			for (int i = 0; i < 16; i++) begin
				add_load(2'(order[i] >> 2), 2'(order[i]), pick_value(), i == 0);
				if ($urandom_range(0, 15) == 0)
					add_op(fpe_pkg::FUNC_RSVD, $urandom(), $urandom(), $urandom(), 1'b0);
			end
			if ($urandom_range(0, 5) != 0 || n_frames < 2)
				add_op(fpe_pkg::FUNC_EXTRACT, $urandom(), $urandom(), $urandom(), 1'b0);
			repeat ($urandom_range(6, 14)) begin
				if ($urandom_range(0, 3) == 0)
					add_op(fpe_pkg::FUNC_QUERY, pick_value(), pick_value(), pick_value(),
						1'b0);
				else
					add_op(fpe_pkg::FUNC_QUERY, $urandom(), $urandom(), $urandom(), 1'b0);
			end
			n_frames++;
		end

		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		do @(posedge clk);
		while (request_queue.size() > 0 || push || pending_results.size() > 0);
		repeat (2000) @(posedge clk);

		$display("%0d requests in %0d random frames: %0d extractions, %0d point queries",
			n_accepted, n_frames, n_extract, n_query);
		$display("%0d results checked, %0d degenerate and %0d saturated planes seen",
			n_checked, n_degenerate, n_saturated);
		if (errors == 0 && pending_results.size() == 0)
			$display("tb_frustum_plane_extract_and_test_unit OK");
		else
			$display("tb_frustum_plane_extract_and_test_unit NOT OK");
		$finish;
	end

endmodule
`default_nettype wire
